### design/i2cmb_pkg.sv
// ----------------------------------------------------------------------------
// i2cmb_pkg: shared types and constants of the i2c master bit engine
// command codes, register map, config and result bundles
// ----------------------------------------------------------------------------
package i2cmb_pkg;

  localparam logic [2:0] CMD_NONE  = 3'd0;
  localparam logic [2:0] CMD_START = 3'd1;
  localparam logic [2:0] CMD_STOP  = 3'd2;
  localparam logic [2:0] CMD_WRITE = 3'd3;
  localparam logic [2:0] CMD_READ  = 3'd4;
  localparam logic [2:0] CMD_ACK   = 3'd5;
  localparam logic [2:0] CMD_NACK  = 3'd6;

  localparam int unsigned ADDR_W = 3;
  localparam logic REG_PHASE_TICKS = 1'b0;
  localparam logic REG_POLL_LIMIT  = 1'b1;

  localparam logic [7:0] PHASE_TICKS_RST = 8'd33;
  localparam logic [7:0] POLL_LIMIT_RST  = 8'd200;

  typedef struct packed {
    logic [7:0] phase_ticks;
    logic [7:0] ack_poll_limit;
  } cfg_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rd_byte;
    logic       ack_fail;
  } res_t;

endpackage

### design/i2cmb_regs.sv
// ----------------------------------------------------------------------------
// i2cmb_regs: configuration registers
// apb-style write and read of phase length and ack poll limit
// ----------------------------------------------------------------------------
module i2cmb_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [i2cmb_pkg::ADDR_W-1:0]  cfg_paddr,
  input  logic [31:0]                   cfg_pwdata,
  output logic [31:0]                   cfg_prdata,
  output logic                          cfg_pready,
  output i2cmb_pkg::cfg_t               cfg
);

  logic [7:0] phase_ticks_r;
  logic [7:0] poll_limit_r;
  logic       wr_en;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_ticks_r <= i2cmb_pkg::PHASE_TICKS_RST;
      poll_limit_r  <= i2cmb_pkg::POLL_LIMIT_RST;
    end else if (wr_en) begin
      case (cfg_paddr[2])
        i2cmb_pkg::REG_PHASE_TICKS: phase_ticks_r <= cfg_pwdata[7:0];
        i2cmb_pkg::REG_POLL_LIMIT:  poll_limit_r  <= cfg_pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[2])
      i2cmb_pkg::REG_PHASE_TICKS: cfg_prdata = {24'd0, phase_ticks_r};
      i2cmb_pkg::REG_POLL_LIMIT:  cfg_prdata = {24'd0, poll_limit_r};
      default:                    cfg_prdata = 32'd0;
    endcase
  end

  assign cfg.phase_ticks    = phase_ticks_r;
  assign cfg.ack_poll_limit = poll_limit_r;

endmodule

### design/i2cmb_step.sv
// ----------------------------------------------------------------------------
// i2cmb_step: line sequencer state and one-tick update
// holds the sequencer state, advances it by one tick per fire
// ----------------------------------------------------------------------------
module i2cmb_step (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             fire,
  input  logic [2:0]       cmd,
  input  logic [7:0]       wr_byte,
  input  logic             sda_in,
  input  i2cmb_pkg::cfg_t  cfg,
  output i2cmb_pkg::res_t  res
);

  typedef struct packed {
    logic [2:0] op;
    logic [1:0] phase;
    logic [3:0] bit_idx;
    logic [7:0] tick;
    logic [7:0] poll;
    logic [7:0] shift;
    logic       scl;
    logic       sda;
    logic       fail;
    logic [7:0] rd_latch;
  } st_t;

  st_t st_r, st_nxt;
  logic done;

  // line actions on entering a phase
  function automatic st_t enter_phase(input st_t s, input logic sin);
    st_t o;
    o = s;
    case (s.op)
      i2cmb_pkg::CMD_START: begin
        case (s.phase)
          2'd0:    o.sda = 1'b1;
          2'd1:    o.scl = 1'b1;
          2'd2:    o.sda = 1'b0;
          default: o.scl = 1'b0;
        endcase
      end
      i2cmb_pkg::CMD_STOP: begin
        case (s.phase)
          2'd1:    o.sda = 1'b0;
          2'd2:    o.scl = 1'b1;
          2'd3:    o.sda = 1'b1;
          default: ;
        endcase
      end
      i2cmb_pkg::CMD_WRITE: begin
        if (s.bit_idx < 4'd8) begin
          if (s.phase == 2'd0) begin
            o.sda   = s.shift[7];
            o.shift = {s.shift[6:0], 1'b0};
          end else if (s.phase == 2'd1) begin
            o.scl = 1'b1;
          end else begin
            o.scl = 1'b0;
          end
        end else begin
          if (s.phase == 2'd0) begin
            o.sda = 1'b1;
          end else if (s.phase == 2'd1) begin
            o.scl  = 1'b1;
            o.poll = 8'd0;
          end else begin
            o.scl = 1'b0;
          end
        end
      end
      i2cmb_pkg::CMD_READ: begin
        if (s.bit_idx == 4'd0) begin
          o.sda = 1'b1;
        end else if (s.phase == 2'd0) begin
          o.scl = 1'b1;
        end else if (s.phase == 2'd1) begin
          o.shift = {s.shift[6:0], sin};
        end else begin
          o.scl = 1'b0;
        end
      end
      i2cmb_pkg::CMD_ACK, i2cmb_pkg::CMD_NACK: begin
        if (s.phase == 2'd0) begin
          o.sda = (s.op == i2cmb_pkg::CMD_NACK);
        end else if (s.phase == 2'd1) begin
          o.scl = 1'b1;
        end else begin
          o.scl = 1'b0;
        end
      end
      default: ;
    endcase
    return o;
  endfunction

  always_comb begin
    logic [7:0] hold;
    logic       fin;
    st_nxt = st_r;
    done   = 1'b0;
    fin    = 1'b0;
    hold   = (cfg.phase_ticks != 8'd0) ? cfg.phase_ticks : 8'd1;
    if (st_r.op == i2cmb_pkg::CMD_NONE) begin
      if (cmd >= i2cmb_pkg::CMD_START && cmd <= i2cmb_pkg::CMD_NACK) begin
        st_nxt.op      = cmd;
        st_nxt.phase   = 2'd0;
        st_nxt.bit_idx = 4'd0;
        st_nxt.tick    = 8'd0;
        st_nxt.poll    = 8'd0;
        if (cmd == i2cmb_pkg::CMD_WRITE) begin
          st_nxt.shift = wr_byte;
        end else if (cmd == i2cmb_pkg::CMD_READ) begin
          st_nxt.shift = 8'd0;
        end
        st_nxt = enter_phase(st_nxt, sda_in);
      end
    end else begin
      st_nxt.tick = 8'(st_r.tick + 8'd1);
      if (st_nxt.tick >= hold) begin
        st_nxt.tick = 8'd0;
        case (st_r.op)
          i2cmb_pkg::CMD_START, i2cmb_pkg::CMD_STOP: begin
            if (st_r.phase < 2'd3) begin
              st_nxt.phase = 2'(st_r.phase + 2'd1);
              st_nxt = enter_phase(st_nxt, sda_in);
            end else begin
              fin = 1'b1;
            end
          end
          i2cmb_pkg::CMD_ACK, i2cmb_pkg::CMD_NACK: begin
            if (st_r.phase < 2'd2) begin
              st_nxt.phase = 2'(st_r.phase + 2'd1);
              st_nxt = enter_phase(st_nxt, sda_in);
            end else begin
              fin = 1'b1;
            end
          end
          i2cmb_pkg::CMD_WRITE: begin
            if (st_r.bit_idx < 4'd8) begin
              if (st_r.phase < 2'd2) begin
                st_nxt.phase = 2'(st_r.phase + 2'd1);
              end else begin
                st_nxt.phase   = 2'd0;
                st_nxt.bit_idx = 4'(st_r.bit_idx + 4'd1);
              end
              st_nxt = enter_phase(st_nxt, sda_in);
            end else if (st_r.phase == 2'd0) begin
              st_nxt.phase = 2'd1;
              st_nxt = enter_phase(st_nxt, sda_in);
            end else if (st_r.phase == 2'd1) begin
              // ack poll: low sample acks, high sample retries until the limit
              if (!sda_in) begin
                st_nxt.phase = 2'd2;
                st_nxt = enter_phase(st_nxt, sda_in);
              end else if (st_r.poll >= cfg.ack_poll_limit) begin
                st_nxt.phase = 2'd3;
                st_nxt = enter_phase(st_nxt, sda_in);
              end else begin
                st_nxt.poll = 8'(st_r.poll + 8'd1);
              end
            end else begin
              st_nxt.fail = (st_r.phase == 2'd3);
              fin = 1'b1;
            end
          end
          i2cmb_pkg::CMD_READ: begin
            if (st_r.bit_idx == 4'd0) begin
              st_nxt.bit_idx = 4'd1;
              st_nxt.phase   = 2'd0;
              st_nxt = enter_phase(st_nxt, sda_in);
            end else if (st_r.phase < 2'd2) begin
              st_nxt.phase = 2'(st_r.phase + 2'd1);
              st_nxt = enter_phase(st_nxt, sda_in);
            end else if (st_r.bit_idx < 4'd8) begin
              st_nxt.bit_idx = 4'(st_r.bit_idx + 4'd1);
              st_nxt.phase   = 2'd0;
              st_nxt = enter_phase(st_nxt, sda_in);
            end else begin
              st_nxt.rd_latch = st_r.shift;
              fin = 1'b1;
            end
          end
          default: fin = 1'b1;
        endcase
        if (fin) begin
          st_nxt.op      = i2cmb_pkg::CMD_NONE;
          st_nxt.phase   = 2'd0;
          st_nxt.bit_idx = 4'd0;
          st_nxt.poll    = 8'd0;
          done           = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.op       <= i2cmb_pkg::CMD_NONE;
      st_r.phase    <= 2'd0;
      st_r.bit_idx  <= 4'd0;
      st_r.tick     <= 8'd0;
      st_r.poll     <= 8'd0;
      st_r.shift    <= 8'd0;
      st_r.scl      <= 1'b1;
      st_r.sda      <= 1'b1;
      st_r.fail     <= 1'b0;
      st_r.rd_latch <= 8'd0;
    end else if (fire) begin
      st_r <= st_nxt;
    end
  end

  assign res.scl_out  = st_nxt.scl;
  assign res.sda_out  = st_nxt.sda;
  assign res.busy_res = (st_nxt.op != i2cmb_pkg::CMD_NONE);
  assign res.done_res = done;
  assign res.rd_byte  = st_nxt.rd_latch;
  assign res.ack_fail = st_nxt.fail;

endmodule

### design/i2c_master_bit_engine.sv
// ----------------------------------------------------------------------------
// i2c_master_bit_engine: tick-driven i2c master line sequencer
// a tick waits in the input register and its result then waits in the result register;
// a stalling result side holds both
// throughput: one tick per clock while the result side is not stalling, one result per tick
// the per-tick sequencer update sits between the input and result registers
// reset (synchronous, rst_n low): engine idle, scl and sda released,
// phase_ticks 33, ack_poll_limit 200, both channels empty
// ----------------------------------------------------------------------------
module i2c_master_bit_engine (
  input  logic                          clk,
  input  logic                          rst_n,
  // tick input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [2:0]                    in_cmd,
  input  logic [7:0]                    in_wr_byte,
  input  logic                          in_sda_in,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_scl_out,
  output logic                          out_sda_out,
  output logic                          out_busy_res,
  output logic                          out_done_res,
  output logic [7:0]                    out_rd_byte,
  output logic                          out_ack_fail,
  // configuration port
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [i2cmb_pkg::ADDR_W-1:0]  cfg_paddr,
  input  logic [31:0]                   cfg_pwdata,
  output logic [31:0]                   cfg_prdata,
  output logic                          cfg_pready
);

  i2cmb_pkg::cfg_t cfg;
  i2cmb_pkg::res_t res;
  i2cmb_pkg::res_t out_r;

  // input register
  logic       in_vld_r;
  logic [2:0] cmd_r;
  logic [7:0] wr_r;
  logic       sda_r;
  logic       out_vld_r;

  logic fire;
  logic in_take;

  // a held tick moves on when the result register is empty or draining
  assign fire     = in_vld_r & (~out_vld_r | ~out_stall);
  assign in_stall = in_vld_r & ~fire;
  assign in_take  = in_valid & ~in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_take) begin
      in_vld_r <= 1'b1;
    end else if (fire) begin
      in_vld_r <= 1'b0;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (in_take) begin
      cmd_r <= in_cmd;
      wr_r  <= in_wr_byte;
      sda_r <= in_sda_in;
    end
  end

  i2cmb_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  // sequencer state advances once per fired tick
  i2cmb_step u_step (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (fire),
    .cmd     (cmd_r),
    .wr_byte (wr_r),
    .sda_in  (sda_r),
    .cfg     (cfg),
    .res     (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (fire) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_r <= res;
    end
  end

  assign out_valid    = out_vld_r;
  assign out_scl_out  = out_r.scl_out;
  assign out_sda_out  = out_r.sda_out;
  assign out_busy_res = out_r.busy_res;
  assign out_done_res = out_r.done_res;
  assign out_rd_byte  = out_r.rd_byte;
  assign out_ack_fail = out_r.ack_fail;

endmodule
